/* hdl/sms_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Servo motion scheduler package
// Shared request codes, status codes, move and divider request record types and a pulse clamp helper.
// ----------------------------------------------------------------------------
package sms_pkg;

    localparam logic [2:0] REQ_TICK   = 3'd0;
    localparam logic [2:0] REQ_PUSH   = 3'd1;
    localparam logic [2:0] REQ_SET    = 3'd2;
    localparam logic [2:0] REQ_PCT    = 3'd3;
    localparam logic [2:0] REQ_CENTER = 3'd4;
    localparam logic [2:0] REQ_RANGE  = 3'd5;
    localparam logic [2:0] REQ_CLEAR  = 3'd6;
    localparam logic [2:0] REQ_QUERY  = 3'd7;

    localparam logic [1:0] STAT_OK     = 2'd0;
    localparam logic [1:0] STAT_BAD_CH = 2'd1;
    localparam logic [1:0] STAT_FULL   = 2'd2;
    localparam logic [1:0] STAT_RANGE  = 2'd3;

    localparam logic KIND_PWM    = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    localparam logic [14:0] LIMIT_LOW_RESET  = 15'd450;
    localparam logic [14:0] LIMIT_HIGH_RESET = 15'd2500;
    localparam logic [15:0] PERIOD_RESET     = 16'd20000;
    localparam logic [12:0] OFF_MAX          = 13'd4096;
    localparam logic [6:0]  PCT_MAX          = 7'd100;
    localparam logic [15:0] TICKS_MAX        = 16'hFFFF;

    // Reciprocal of 100, exact for dividends below 2**22.
    localparam int          PCT_SH  = 29;
    localparam logic [22:0] PCT_MUL = 23'd5368710;

    typedef struct packed {
        logic [14:0] target;
        logic [15:0] ticks;
        logic [31:0] step;
        logic [14:0] start;
    } t_move;

    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [15:0] divisor;
    } t_div_req;

    function automatic logic [14:0] clamp_pulse(input logic [31:0] p,
                                                input logic [14:0] lo,
                                                input logic [14:0] hi);
        logic [31:0] v;
        v = p;
        if (v < 32'(lo)) begin
            v = 32'(lo);
        end
        if (v > 32'(hi)) begin
            v = 32'(hi);
        end
        return v[14:0];
    endfunction

endpackage
`default_nettype wire

/* hdl/sms_div.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Servo motion scheduler divider
// Unsigned restoring divider, 32-bit dividend by 16-bit divisor, one
// quotient bit per cycle.
// ----------------------------------------------------------------------------
module sms_div (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire sms_pkg::t_div_req i_req,
    output logic                 o_done,
    output logic [31:0]          o_quotient
);

    logic        r_busy;
    logic        r_done;
    logic [4:0]  r_cnt;
    logic [31:0] r_q;
    logic [15:0] r_rem;
    logic [15:0] r_div;
    logic [16:0] rem_sh;
    logic        ge;
    logic [16:0] rem_sub;
    logic [15:0] n_rem;

    always_comb begin
        rem_sh  = {r_rem, r_q[31]};
        ge      = rem_sh >= {1'b0, r_div};
        rem_sub = rem_sh - {1'b0, r_div};
        n_rem   = ge ? rem_sub[15:0] : rem_sh[15:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_q   <= i_req.dividend;
            r_rem <= '0;
            r_div <= i_req.divisor;
        end else if (r_busy) begin
            r_q   <= {r_q[30:0], ge};
            r_rem <= n_rem;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_q;

endmodule
`default_nettype wire

/* hdl/servo_motion_scheduler_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Servo motion scheduler unit
// Per-channel queues of timed servo moves with limits and PWM write output.
// ----------------------------------------------------------------------------
// The unit takes one request item at a time and answers with zero or more PWM
// write items followed by one status item marked by tlast. Divisions by the
// move length and by the PWM period run on one shared bit-serial divider,
// while divisions by the tick length and by 100 use reciprocal multiplication.
// A push runs one step division; set pulse, center and percent each run one
// off-count division, and set range, clear and query run none. A tick walks
// the channels one after another, and for each channel whose pulse changes
// it runs one off-count division and emits one PWM write item. Moves live in
// one single-port-read synchronous memory of CHANNELS*QUEUE_DEPTH records
// whose contents need no clearing after reset. Output stalls hold the
// sequencer.
module servo_motion_scheduler_unit #(
    parameter int CHANNELS    = 32,
    parameter int QUEUE_DEPTH = 16,
    parameter int TICK_MS     = 10,
    parameter int FRAC_BITS   = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // channel, pulse_value, duration_ms, percent, range_low, range_high,
    // ignore_range, clear_schedule, replace_queue
    input  wire logic [79:0] s_tdata,
    // req_type
    input  wire logic [2:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // out_channel, off_count, status, plan_pending, planned_pulse, busy_mask
    output logic [71:0]      m_tdata,
    // kind
    output logic             m_tuser,
    output logic             m_tlast,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int CW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int QW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNTW  = $clog2(QUEUE_DEPTH + 1);
    localparam int SW    = CNTW + 1;
    localparam int SLOTS = CHANNELS * QUEUE_DEPTH;
    localparam int AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    // Reciprocal of the tick length, exact for 16-bit durations.
    localparam int          TICK_SH  = 16 + $clog2(TICK_MS);
    localparam logic [17:0] TICK_MUL =
        18'(((64'd1 << TICK_SH) + 64'(TICK_MS) - 64'd1) / 64'(TICK_MS));

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_REQ    = 5'd1;
    localparam logic [4:0] S_P1     = 5'd2;
    localparam logic [4:0] S_P2W    = 5'd3;
    localparam logic [4:0] S_P3W    = 5'd4;
    localparam logic [4:0] S_PCT_W  = 5'd5;
    localparam logic [4:0] S_DRIVE  = 5'd6;
    localparam logic [4:0] S_OFF    = 5'd7;
    localparam logic [4:0] S_OFF_W  = 5'd8;
    localparam logic [4:0] S_EM_PWM = 5'd9;
    localparam logic [4:0] S_EM_ST  = 5'd10;
    localparam logic [4:0] S_T_CHK  = 5'd11;
    localparam logic [4:0] S_T_RD   = 5'd12;
    localparam logic [4:0] S_T_LD   = 5'd13;
    localparam logic [4:0] S_T_LDW  = 5'd14;
    localparam logic [4:0] S_T_NEXT = 5'd15;

    logic [4:0]   r_state;
    logic [15:0]  r_period;

    logic [2:0]   r_type;
    logic [4:0]   r_ich;
    logic [14:0]  r_pv;
    logic [15:0]  r_dur;
    logic [7:0]   r_pct;
    logic [14:0]  r_rlo;
    logic [14:0]  r_rhi;
    logic         r_ign;
    logic         r_clr;
    logic         r_repl;
    logic         r_tick;

    logic [CW-1:0] r_ch;
    logic [1:0]    r_status;
    logic [14:0]   r_pulse;
    logic          r_chg;
    logic [12:0]   r_off;
    logic [14:0]   r_tgt;
    logic [14:0]   r_start;
    logic [15:0]   r_ticks;
    logic          r_neg;
    logic [21:0]   r_prod;

    logic [QW-1:0]   r_head     [CHANNELS];
    logic [CNTW-1:0] r_count    [CHANNELS];
    logic [15:0]     r_elapsed  [CHANNELS];
    logic [31:0]     r_position [CHANNELS];
    logic [14:0]     r_last     [CHANNELS];
    logic [14:0]     r_lo       [CHANNELS];
    logic [14:0]     r_hi       [CHANNELS];
    logic [14:0]     r_plan     [CHANNELS];

    sms_pkg::t_move r_mem [SLOTS];
    sms_pkg::t_move r_rd;

    logic          r_mvalid;
    logic [71:0]   r_mdata;
    logic          r_muser;
    logic          r_mlast;

    sms_pkg::t_div_req div_req;
    logic              div_done;
    logic [31:0]       div_q;

    logic [AW-1:0]  rd_addr;
    logic [AW-1:0]  wr_addr;
    logic [SW-1:0]  wr_sum;
    logic [SW-1:0]  wr_idx;
    logic           mem_we;
    sms_pkg::t_move mem_wdata;

    logic [14:0]   cur_lo;
    logic [14:0]   cur_hi;
    logic [CNTW-1:0] cur_count;
    logic          full_now;
    logic [14:0]   tgt_c;
    logic [14:0]   start_c;
    logic [33:0]   tick_prod_c;
    logic [15:0]   tick_q_c;
    logic [15:0]   ticks_c;
    logic [15:0]   diff_c;
    logic [15:0]   abs_c;
    logic [31:0]   mag_c;
    logic [31:0]   step_c;
    logic [14:0]   span_c;
    logic [6:0]    pct_c;
    logic [21:0]   prod_c;
    logic [44:0]   pct_prod_c;
    logic [15:0]   pct_q_c;
    logic [15:0]   mid_c;
    logic [15:0]   pct_sum_c;

    logic signed [32:0] pos_c;
    logic [32:0]   posc_c;
    logic [33:0]   rnd_c;
    logic [33:0]   sh_c;
    logic [14:0]   cl_c;
    logic [15:0]   el_inc_c;
    logic          mv_done_c;
    logic [14:0]   tick_pulse_c;
    logic [SW-1:0] head_inc_c;
    logic [QW-1:0] head_nxt_c;
    logic [CNTW-1:0] cnt_dec_c;

    logic [31:0]   busy;
    logic          em_pwm;
    logic          em_fire;
    logic [CW-1:0] em_idx;
    logic          ich_ok;
    logic          em_ok;
    logic          em_pend;
    logic [14:0]   em_plan;
    logic [4:0]    em_ch;
    logic [12:0]   em_off;
    logic [1:0]    em_stat;
    logic          cfg_wr;

    sms_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (div_req),
        .o_done    (div_done),
        .o_quotient(div_q)
    );

    // Configuration port.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == 1'b0);
    assign prdata = (paddr[2] == 1'b0) ? {16'd0, r_period} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= sms_pkg::PERIOD_RESET;
        end else if (cfg_wr) begin
            r_period <= pwdata[15:0];
        end
    end

    // Busy mask and per-channel views.
    genvar g;
    generate
        for (g = 0; g < 32; g++) begin : g_busy
            if (g < CHANNELS) begin : g_on
                assign busy[g] = (r_count[g] != '0);
            end else begin : g_off
                assign busy[g] = 1'b0;
            end
        end
    endgenerate

    always_comb begin
        cur_lo    = r_lo[r_ch];
        cur_hi    = r_hi[r_ch];
        cur_count = r_count[r_ch];
        full_now  = cur_count >= CNTW'(QUEUE_DEPTH);
        tgt_c     = sms_pkg::clamp_pulse(32'(r_pv), cur_lo, cur_hi);
        start_c   = (cur_count == '0) ? r_last[r_ch] : r_plan[r_ch];
        tick_prod_c = 34'(r_dur) * 34'(TICK_MUL);
        tick_q_c    = 16'(tick_prod_c >> TICK_SH);
        if (tick_q_c == sms_pkg::TICKS_MAX) begin
            ticks_c = sms_pkg::TICKS_MAX;
        end else begin
            ticks_c = tick_q_c + 16'd1;
        end
        diff_c    = {1'b0, r_tgt} - {1'b0, r_start};
        abs_c     = diff_c[15] ? (16'd0 - diff_c) : diff_c;
        mag_c     = 32'(abs_c) << FRAC_BITS;
        step_c    = r_neg ? (32'd0 - div_q) : div_q;
        span_c    = (cur_hi > cur_lo) ? (cur_hi - cur_lo) : 15'd0;
        pct_c     = (r_pct > 8'(sms_pkg::PCT_MAX)) ? sms_pkg::PCT_MAX : r_pct[6:0];
        prod_c    = 22'(span_c) * 22'(pct_c);
        pct_prod_c = 45'(r_prod) * 45'(sms_pkg::PCT_MUL);
        pct_q_c    = 16'(pct_prod_c >> sms_pkg::PCT_SH);
        mid_c     = (16'(cur_lo) + 16'(cur_hi)) >> 1;
        pct_sum_c = pct_q_c + 16'(cur_lo);

        pos_c     = $signed({r_position[r_ch][31], r_position[r_ch]})
                  + $signed({r_rd.step[31], r_rd.step});
        posc_c    = pos_c[32] ? 33'd0 : pos_c;
        rnd_c     = {1'b0, posc_c} + 34'((64'd1 << FRAC_BITS) - 64'd1);
        sh_c      = rnd_c >> FRAC_BITS;
        cl_c      = sms_pkg::clamp_pulse(sh_c[31:0], cur_lo, cur_hi);
        el_inc_c  = r_elapsed[r_ch] + 16'd1;
        mv_done_c = el_inc_c >= r_rd.ticks;
        tick_pulse_c = mv_done_c ? r_rd.target : cl_c;
        head_inc_c = SW'(r_head[r_ch]) + SW'(1);
        head_nxt_c = (head_inc_c >= SW'(QUEUE_DEPTH)) ? '0 : head_inc_c[QW-1:0];
        cnt_dec_c  = cur_count - CNTW'(1);
    end

    // Divider requests.
    always_comb begin
        div_req.start    = 1'b0;
        div_req.dividend = 32'd0;
        div_req.divisor  = 16'd0;
        unique case (r_state)
            S_P2W: begin
                div_req.start    = 1'b1;
                div_req.dividend = mag_c;
                div_req.divisor  = r_ticks;
            end
            S_OFF: begin
                div_req.start    = 1'b1;
                div_req.dividend = {5'd0, r_pulse, 12'd0};
                div_req.divisor  = r_period;
            end
            default: begin
                div_req.start = 1'b0;
            end
        endcase
    end

    // Move memory.
    always_comb begin
        wr_sum    = SW'(r_head[r_ch]) + SW'(cur_count);
        wr_idx    = (wr_sum >= SW'(QUEUE_DEPTH)) ? (wr_sum - SW'(QUEUE_DEPTH)) : wr_sum;
        rd_addr   = AW'(r_ch) * AW'(QUEUE_DEPTH) + AW'(r_head[r_ch]);
        wr_addr   = AW'(r_ch) * AW'(QUEUE_DEPTH) + AW'(wr_idx);
        mem_we    = (r_state == S_P3W) && div_done;
        mem_wdata = '{target: r_tgt, ticks: r_ticks, step: step_c, start: r_start};
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[wr_addr] <= mem_wdata;
        end
        r_rd <= r_mem[rd_addr];
    end

    // Result assembly.
    always_comb begin
        em_pwm  = (r_state == S_EM_PWM);
        em_fire = (em_pwm || r_state == S_EM_ST) && (!r_mvalid || m_tready);
        ich_ok  = {1'b0, r_ich} < 6'(CHANNELS);
        em_idx  = em_pwm ? r_ch : r_ich[CW-1:0];
        em_ok   = em_pwm || ich_ok;
        em_pend = em_ok && (r_count[em_idx] != '0);
        em_plan = em_pend ? r_plan[em_idx] : 15'd0;
        em_ch   = em_pwm ? 5'(r_ch) : r_ich;
        em_off  = em_pwm ? r_off : 13'd0;
        em_stat = em_pwm ? sms_pkg::STAT_OK : r_status;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mvalid <= 1'b0;
        end else if (em_fire) begin
            r_mvalid <= 1'b1;
        end else if (m_tready) begin
            r_mvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (em_fire) begin
            r_mdata <= {4'd0, busy, em_plan, em_pend, em_stat, em_off, em_ch};
            r_muser <= em_pwm ? sms_pkg::KIND_PWM : sms_pkg::KIND_STATUS;
            r_mlast <= !em_pwm;
        end
    end

    assign m_tvalid = r_mvalid;
    assign m_tdata  = r_mdata;
    assign m_tuser  = r_muser;
    assign m_tlast  = r_mlast;
    assign s_tready = (r_state == S_IDLE);

    // Request sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            for (int c = 0; c < CHANNELS; c++) begin
                r_head[c]     <= '0;
                r_count[c]    <= '0;
                r_elapsed[c]  <= '0;
                r_position[c] <= '0;
                r_last[c]     <= '0;
                r_lo[c]       <= sms_pkg::LIMIT_LOW_RESET;
                r_hi[c]       <= sms_pkg::LIMIT_HIGH_RESET;
            end
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (s_tvalid) begin
                        r_type   <= s_tuser;
                        r_ich    <= s_tdata[4:0];
                        r_pv     <= s_tdata[19:5];
                        r_dur    <= s_tdata[35:20];
                        r_pct    <= s_tdata[43:36];
                        r_rlo    <= s_tdata[58:44];
                        r_rhi    <= s_tdata[73:59];
                        r_ign    <= s_tdata[74];
                        r_clr    <= s_tdata[75];
                        r_repl   <= s_tdata[76];
                        r_status <= sms_pkg::STAT_OK;
                        r_tick   <= (s_tuser == sms_pkg::REQ_TICK);
                        if (s_tuser == sms_pkg::REQ_TICK) begin
                            r_ch    <= '0;
                            r_state <= S_T_CHK;
                        end else if ({1'b0, s_tdata[4:0]} >= 6'(CHANNELS)) begin
                            r_status <= sms_pkg::STAT_BAD_CH;
                            r_state  <= S_EM_ST;
                        end else begin
                            r_ch    <= s_tdata[CW-1:0];
                            r_state <= S_REQ;
                        end
                    end
                end
                S_REQ: begin
                    unique case (r_type)
                        sms_pkg::REQ_PUSH: begin
                            if (r_repl) begin
                                r_count[r_ch] <= '0;
                            end
                            r_state <= S_P1;
                        end
                        sms_pkg::REQ_SET: begin
                            r_pulse <= r_ign ? r_pv
                                     : sms_pkg::clamp_pulse(32'(r_pv), cur_lo, cur_hi);
                            r_state <= S_DRIVE;
                        end
                        sms_pkg::REQ_PCT: begin
                            r_prod  <= prod_c;
                            r_state <= S_PCT_W;
                        end
                        sms_pkg::REQ_CENTER: begin
                            r_pulse <= sms_pkg::clamp_pulse(32'(mid_c), cur_lo, cur_hi);
                            r_state <= S_DRIVE;
                        end
                        sms_pkg::REQ_RANGE: begin
                            if (r_rlo >= r_rhi) begin
                                r_status <= sms_pkg::STAT_RANGE;
                            end else begin
                                r_lo[r_ch] <= r_rlo;
                                r_hi[r_ch] <= r_rhi;
                            end
                            r_state <= S_EM_ST;
                        end
                        sms_pkg::REQ_CLEAR: begin
                            r_count[r_ch] <= '0;
                            r_state <= S_EM_ST;
                        end
                        default: begin
                            r_state <= S_EM_ST;
                        end
                    endcase
                end
                S_P1: begin
                    if (full_now) begin
                        r_status <= sms_pkg::STAT_FULL;
                        r_state  <= S_EM_ST;
                    end else begin
                        r_tgt   <= tgt_c;
                        r_start <= start_c;
                        r_ticks <= ticks_c;
                        r_state <= S_P2W;
                    end
                end
                S_P2W: begin
                    r_neg   <= diff_c[15];
                    r_state <= S_P3W;
                end
                S_P3W: begin
                    if (div_done) begin
                        r_count[r_ch] <= cur_count + CNTW'(1);
                        r_plan[r_ch]  <= r_tgt;
                        if (cur_count == '0) begin
                            r_elapsed[r_ch]  <= '0;
                            r_position[r_ch] <= 32'(r_start) << FRAC_BITS;
                        end
                        r_state <= S_EM_ST;
                    end
                end
                S_PCT_W: begin
                    r_pulse <= sms_pkg::clamp_pulse(32'(pct_sum_c), cur_lo, cur_hi);
                    r_state <= S_DRIVE;
                end
                S_DRIVE: begin
                    r_last[r_ch] <= r_pulse;
                    if (r_clr) begin
                        r_count[r_ch] <= '0;
                    end
                    r_state <= S_OFF;
                end
                S_OFF: begin
                    r_state <= S_OFF_W;
                end
                S_OFF_W: begin
                    if (div_done) begin
                        if (r_period == 16'd0 || div_q > 32'(sms_pkg::OFF_MAX)) begin
                            r_off <= sms_pkg::OFF_MAX;
                        end else begin
                            r_off <= div_q[12:0];
                        end
                        r_state <= S_EM_PWM;
                    end
                end
                S_EM_PWM: begin
                    if (em_fire) begin
                        r_state <= r_tick ? S_T_NEXT : S_EM_ST;
                    end
                end
                S_EM_ST: begin
                    if (em_fire) begin
                        r_state <= S_IDLE;
                    end
                end
                S_T_CHK: begin
                    r_state <= (cur_count == '0) ? S_T_NEXT : S_T_RD;
                end
                S_T_RD: begin
                    r_elapsed[r_ch]  <= el_inc_c;
                    r_position[r_ch] <= pos_c[31:0];
                    r_pulse <= tick_pulse_c;
                    r_chg   <= (r_last[r_ch] != tick_pulse_c);
                    r_last[r_ch] <= tick_pulse_c;
                    if (mv_done_c) begin
                        r_head[r_ch]  <= head_nxt_c;
                        r_count[r_ch] <= cnt_dec_c;
                    end
                    if (mv_done_c && cnt_dec_c != '0) begin
                        r_state <= S_T_LD;
                    end else if (r_last[r_ch] != tick_pulse_c) begin
                        r_state <= S_OFF;
                    end else begin
                        r_state <= S_T_NEXT;
                    end
                end
                S_T_LD: begin
                    r_state <= S_T_LDW;
                end
                S_T_LDW: begin
                    r_elapsed[r_ch]  <= '0;
                    r_position[r_ch] <= 32'(r_rd.start) << FRAC_BITS;
                    r_state <= r_chg ? S_OFF : S_T_NEXT;
                end
                S_T_NEXT: begin
                    if (r_ch == CW'(CHANNELS - 1)) begin
                        r_state <= S_EM_ST;
                    end else begin
                        r_ch    <= r_ch + CW'(1);
                        r_state <= S_T_CHK;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire
